// ----- rtl/core/qfts_pkg.sv -----
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared types and constants for the two-stack queue: data width, command
// and status codes, stack control bundle and controller states.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int DATA_W      = 32;
    localparam int DEPTH_DEF   = 16;
    localparam int CAP_W       = 5;
    localparam int STATUS_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // per-stack control bundle
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctrl_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_POP
    } state_t;

endpackage

// ----- rtl/core/qfts_cell.sv -----
// ----------------------------------------------------------------------------
// qfts_cell
// One stack cell: holds a word, takes the word above on a push and the word
// below on a pop.
// ----------------------------------------------------------------------------
module qfts_cell #(
    parameter int Width = qfts_pkg::DATA_W
) (
    input  logic             clk,
    input  logic             push,
    input  logic             pop,
    input  logic [Width-1:0] above_data,
    input  logic [Width-1:0] below_data,
    output logic [Width-1:0] data
);

    logic [Width-1:0] data_reg;
    logic [Width-1:0] data_next;

    // shift towards the bottom on push, towards the top on pop
    always_comb
    begin
        data_next = data_reg;
        if (push)
        begin
            data_next = above_data;
        end
        else if (pop)
        begin
            data_next = below_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/qfts_stack.sv -----
// ----------------------------------------------------------------------------
// qfts_stack
// Shift-register stack: a row of cells with the top in cell zero, plus the
// fill count.
// ----------------------------------------------------------------------------
module qfts_stack #(
    parameter int Depth = qfts_pkg::DEPTH_DEF,
    parameter int Width = qfts_pkg::DATA_W,
    localparam int CntW = $clog2(Depth + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qfts_pkg::stack_ctrl_t ctrl,
    input  logic [Width-1:0]      push_data,
    output logic [Width-1:0]      top_data,
    output logic [CntW-1:0]       count
);

    logic [Width-1:0] cell_data [Depth];
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;

    // row of cells, each fed by its neighbours
    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        logic [Width-1:0] above;
        logic [Width-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = push_data;
        end
        else
        begin : g_mid
            assign above = cell_data[i-1];
        end

        if (i == Depth - 1)
        begin : g_bottom
            assign below = cell_data[i];
        end
        else
        begin : g_inner
            assign below = cell_data[i+1];
        end

        qfts_cell #(
            .Width(Width)
        ) u_cell (
            .clk       (clk),
            .push      (ctrl.push),
            .pop       (ctrl.pop),
            .above_data(above),
            .below_data(below),
            .data      (cell_data[i])
        );
    end

    // fill count, clear wins
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top_data = cell_data[0];
    assign count    = count_reg;

endmodule

// ----- rtl/core/queue_from_two_stacks_unit.sv -----
// ----------------------------------------------------------------------------
// queue_from_two_stacks_unit
// FIFO queue built from an inbound and an outbound shift-register stack.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  command   start, cmd, value_in, busy     in         start & !busy
//  result    done, value_out, status        out        done, one cycle
//  config    cfg_we, cfg_wdata              in         cfg_we
//
//  Enqueue and dequeue from a non-empty outbound stack complete without
//  leaving idle; the result appears on the cycle after the start.
//  Dequeue with an empty outbound stack moves min(inbound count, effective
//  capacity) entries one per cycle through the stack cells, clears the
//  inbound stack, then pops; busy is high meanwhile.
//  Reset clears both counts and the controller and sets capacity to 16.
//  Results cannot be held off; a new command may be taken while done is high.
// ----------------------------------------------------------------------------
module queue_from_two_stacks_unit #(
    parameter int Depth = qfts_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic signed [qfts_pkg::DATA_W-1:0]  value_in,
    output logic                                done,
    output logic signed [qfts_pkg::DATA_W-1:0]  value_out,
    output logic [qfts_pkg::STATUS_W-1:0]       status,
    input  logic                                cfg_we,
    input  logic [qfts_pkg::CAP_W-1:0]          cfg_wdata
);

    localparam int CntW = $clog2(Depth + 1);

    qfts_pkg::state_t          state_reg;
    qfts_pkg::state_t          state_next;
    logic [CntW-1:0]           xfer_left_reg;
    logic [CntW-1:0]           xfer_left_next;
    logic                      done_reg;
    logic                      done_next;
    logic [qfts_pkg::DATA_W-1:0]   value_out_reg;
    logic [qfts_pkg::DATA_W-1:0]   value_out_next;
    logic [qfts_pkg::STATUS_W-1:0] status_reg;
    logic [qfts_pkg::STATUS_W-1:0] status_next;
    logic [qfts_pkg::CAP_W-1:0]    capacity_reg;

    qfts_pkg::stack_ctrl_t     in_ctrl;
    qfts_pkg::stack_ctrl_t     out_ctrl;
    logic [qfts_pkg::DATA_W-1:0] in_top;
    logic [qfts_pkg::DATA_W-1:0] out_top;
    logic [CntW-1:0]           in_cnt;
    logic [CntW-1:0]           out_cnt;
    logic [CntW-1:0]           eff_cap;
    logic [CntW-1:0]           moved;

    // inbound and outbound stacks
    qfts_stack #(
        .Depth(Depth),
        .Width(qfts_pkg::DATA_W)
    ) u_in_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (in_ctrl),
        .push_data(value_in),
        .top_data (in_top),
        .count    (in_cnt)
    );

    qfts_stack #(
        .Depth(Depth),
        .Width(qfts_pkg::DATA_W)
    ) u_out_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (out_ctrl),
        .push_data(in_top),
        .top_data (out_top),
        .count    (out_cnt)
    );

    // effective capacity, clamped to one and to the stack depth
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CntW'(1);
        end
        else if (int'(capacity_reg) > Depth)
        begin
            eff_cap = CntW'(Depth);
        end
        else
        begin
            eff_cap = CntW'(capacity_reg);
        end
        moved = (in_cnt < eff_cap) ? in_cnt : eff_cap;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qfts_pkg::S_IDLE:
            begin
                if (start && cmd == qfts_pkg::CMD_DEQ && out_cnt == '0 && in_cnt != '0)
                begin
                    state_next = qfts_pkg::S_XFER;
                end
            end
            qfts_pkg::S_XFER:
            begin
                if (xfer_left_reg == CntW'(1))
                begin
                    state_next = qfts_pkg::S_POP;
                end
            end
            qfts_pkg::S_POP:
            begin
                state_next = qfts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = qfts_pkg::S_IDLE;
            end
        endcase
    end

    // stack controls and result
    always_comb
    begin
        in_ctrl        = '0;
        out_ctrl       = '0;
        xfer_left_next = xfer_left_reg;
        done_next      = 1'b0;
        value_out_next = '0;
        status_next    = qfts_pkg::ST_OK;
        case (state_reg)
            qfts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == qfts_pkg::CMD_ENQ)
                    begin
                        done_next = 1'b1;
                        if (in_cnt >= eff_cap)
                        begin
                            status_next = qfts_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            in_ctrl.push = 1'b1;
                        end
                    end
                    else if (out_cnt != '0)
                    begin
                        out_ctrl.pop   = 1'b1;
                        done_next      = 1'b1;
                        value_out_next = out_top;
                    end
                    else if (in_cnt == '0)
                    begin
                        done_next      = 1'b1;
                        value_out_next = '1;
                        status_next    = qfts_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        xfer_left_next = moved;
                    end
                end
            end
            qfts_pkg::S_XFER:
            begin
                // newest first, so the oldest moved entry lands on top
                in_ctrl.pop    = 1'b1;
                out_ctrl.push  = 1'b1;
                xfer_left_next = xfer_left_reg - CntW'(1);
                if (xfer_left_reg == CntW'(1))
                begin
                    in_ctrl.clear = 1'b1;
                end
            end
            qfts_pkg::S_POP:
            begin
                out_ctrl.pop   = 1'b1;
                done_next      = 1'b1;
                value_out_next = out_top;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qfts_pkg::S_IDLE;
            xfer_left_reg <= '0;
            done_reg      <= 1'b0;
            capacity_reg  <= qfts_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            xfer_left_reg <= xfer_left_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
    end

    assign busy      = (state_reg != qfts_pkg::S_IDLE);
    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

endmodule
